// ===== rtl/wlm_pkg.sv =====
// wlm_pkg: shared types, register indexes and reset values for the
// windowed latency monitor; no dependencies
package wlm_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH   = 2'd2;

  // register reset values
  localparam logic [31:0] SLOW_THRESHOLD_RST  = 32'd1000;
  localparam logic [31:0] STALL_THRESHOLD_RST = 32'd50000;
  localparam logic [31:0] WINDOW_LENGTH_RST   = 32'd1000;

  // configuration register set
  typedef struct packed {
    logic [31:0] slow_threshold_us;
    logic [31:0] stall_threshold_us;
    logic [31:0] window_length_ms;
  } cfg_t;

  // input item
  typedef struct packed {
    logic [31:0] pass_time_us;
    logic [31:0] gap_time_us;
    logic [47:0] now_ms;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [31:0] pass_count;
    logic [47:0] pass_time_sum;
    logic [31:0] pass_time_max;
    logic [31:0] slow_count;
    logic [31:0] gap_max;
    logic [31:0] pass_after_gap_max;
    logic [31:0] stall_count;
  } out_item_t;

  // saturating 32-bit increment
  function automatic logic [31:0] inc_sat32(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

// ===== rtl/windowed_latency_monitor.sv =====
// windowed_latency_monitor: top level with input and result registers
// depends on wlm_pkg, wlm_cfg_regs, wlm_stats
//
//   channel  | ports                             | payload
//   ---------+-----------------------------------+------------------
//   input    | in_valid, in_stall, in_data       | wlm_pkg::in_item_t
//   result   | out_valid, out_stall, out_data    | wlm_pkg::out_item_t
//   config   | cfg_we, cfg_index, cfg_wdata      | 32-bit register
//
// one item per cycle sustained; an item that closes a window with activity waits in
// the input register, and its report is registered in the result register and offered
// from it; the only back-pressure comes from a full result register held by out_stall
// synchronous active-low reset restores register defaults and clears the window
module windowed_latency_monitor (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  wlm_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output wlm_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [wlm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wdata
);

  wlm_pkg::cfg_t      cfg;
  wlm_pkg::in_item_t  in_data_r;
  logic               in_valid_r;
  wlm_pkg::out_item_t out_data_r;
  logic               out_valid_r;
  logic               proc_go;
  logic               in_take;
  logic               emit;
  wlm_pkg::out_item_t report;

  // configuration registers
  wlm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // pipeline control: process when the result slot is free or draining
  assign proc_go  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !proc_go;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (proc_go) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
  end

  // statistics and window logic
  wlm_stats u_stats (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (proc_go),
    .cfg    (cfg),
    .item   (in_data_r),
    .emit   (emit),
    .report (report)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_go) begin
      out_valid_r <= emit;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && emit) begin
      out_data_r <= report;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/wlm_cfg_regs.sv =====
// wlm_cfg_regs: threshold and window length registers with write decode
// depends on wlm_pkg
module wlm_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [wlm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wdata,
  output wlm_pkg::cfg_t                 cfg
);

  wlm_pkg::cfg_t cfg_r;
  wlm_pkg::cfg_t cfg_nxt;

  // write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        wlm_pkg::CFG_SLOW_THRESHOLD:  cfg_nxt.slow_threshold_us  = cfg_wdata;
        wlm_pkg::CFG_STALL_THRESHOLD: cfg_nxt.stall_threshold_us = cfg_wdata;
        wlm_pkg::CFG_WINDOW_LENGTH:   cfg_nxt.window_length_ms   = cfg_wdata;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slow_threshold_us  <= wlm_pkg::SLOW_THRESHOLD_RST;
      cfg_r.stall_threshold_us <= wlm_pkg::STALL_THRESHOLD_RST;
      cfg_r.window_length_ms   <= wlm_pkg::WINDOW_LENGTH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/wlm_stats.sv =====
// wlm_stats: window statistics registers, single-pass update and window close
// depends on wlm_pkg
module wlm_stats (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  wlm_pkg::cfg_t        cfg,
  input  wlm_pkg::in_item_t    item,
  output logic                 emit,
  output wlm_pkg::out_item_t   report
);

  logic [47:0] window_start_r;
  logic [31:0] passes_r;
  logic [47:0] sum_r;
  logic [31:0] dur_max_r;
  logic [31:0] gap_max_r;
  logic [31:0] dur_at_gap_r;
  logic [31:0] slow_r;
  logic [31:0] stalls_r;

  logic [31:0] passes_nxt;
  logic [47:0] sum_nxt;
  logic [31:0] dur_max_nxt;
  logic [31:0] gap_max_nxt;
  logic [31:0] dur_at_gap_nxt;
  logic [31:0] slow_nxt;
  logic [31:0] stalls_nxt;
  logic [47:0] window_start_nxt;

  logic [48:0] sum_wide;
  logic [47:0] start_eff;
  logic [47:0] elapsed;
  logic        close;

  // per-item statistics update
  always_comb begin
    passes_nxt = wlm_pkg::inc_sat32(passes_r);
    sum_wide   = {1'b0, sum_r} + {17'd0, item.pass_time_us};
    sum_nxt    = sum_wide[48] ? 48'hFFFF_FFFF_FFFF : sum_wide[47:0];
    dur_max_nxt = (item.pass_time_us > dur_max_r) ? item.pass_time_us : dur_max_r;
    slow_nxt   = (item.pass_time_us > cfg.slow_threshold_us) ?
                 wlm_pkg::inc_sat32(slow_r) : slow_r;
    stalls_nxt = (item.gap_time_us > cfg.stall_threshold_us) ?
                 wlm_pkg::inc_sat32(stalls_r) : stalls_r;
    // ties keep the earlier longest gap
    if (item.gap_time_us > gap_max_r) begin
      gap_max_nxt    = item.gap_time_us;
      dur_at_gap_nxt = item.pass_time_us;
    end else begin
      gap_max_nxt    = gap_max_r;
      dur_at_gap_nxt = dur_at_gap_r;
    end
  end

  // window timing: zero start means not started, elapsed wraps at 48 bits
  always_comb begin
    start_eff = (window_start_r == 48'd0) ? item.now_ms : window_start_r;
    elapsed   = item.now_ms - start_eff;
    close     = elapsed >= {16'd0, cfg.window_length_ms};
    window_start_nxt = close ? item.now_ms : start_eff;
    emit      = close && ((slow_nxt != 32'd0) || (stalls_nxt != 32'd0));
  end

  // report contents
  always_comb begin
    report.pass_count         = passes_nxt;
    report.pass_time_sum      = sum_nxt;
    report.pass_time_max      = dur_max_nxt;
    report.slow_count         = slow_nxt;
    report.gap_max            = gap_max_nxt;
    report.pass_after_gap_max = dur_at_gap_nxt;
    report.stall_count        = stalls_nxt;
  end

  // state update; statistics cleared and start moved when the window closes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_start_r <= '0;
      passes_r       <= '0;
      sum_r          <= '0;
      dur_max_r      <= '0;
      gap_max_r      <= '0;
      dur_at_gap_r   <= '0;
      slow_r         <= '0;
      stalls_r       <= '0;
    end else if (go) begin
      window_start_r <= window_start_nxt;
      if (close) begin
        passes_r     <= '0;
        sum_r        <= '0;
        dur_max_r    <= '0;
        gap_max_r    <= '0;
        dur_at_gap_r <= '0;
        slow_r       <= '0;
        stalls_r     <= '0;
      end else begin
        passes_r     <= passes_nxt;
        sum_r        <= sum_nxt;
        dur_max_r    <= dur_max_nxt;
        gap_max_r    <= gap_max_nxt;
        dur_at_gap_r <= dur_at_gap_nxt;
        slow_r       <= slow_nxt;
        stalls_r     <= stalls_nxt;
      end
    end
  end

endmodule

// ===== rtl/wlm_checker.sv =====
// wlm_checker: port-level checks on the windowed latency monitor, bound to the top
// depends on wlm_pkg and windowed_latency_monitor
module wlm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input wlm_pkg::out_item_t out_data
);

  // a stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // input back-pressure only comes from a stalled pending result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without result back-pressure");

  // reset empties both registers
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // after a free result side, the input stalls only with a result pending
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |=> !in_stall || out_valid)
    else $error("input stalled while result side empty");

endmodule

bind windowed_latency_monitor wlm_checker u_wlm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== verif/wlm_report_checker.sv =====
`timescale 1ns / 100ps
// wlm_report_checker: watches the transfers of the windowed latency monitor, predicts
// its window reports and compares them in order; depends on wlm_pkg
module wlm_report_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  wlm_pkg::in_item_t             in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  wlm_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [wlm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wdata,
  output int                            errors,
  output int                            reports_due_n
);

  localparam int PRINT_CAP = 40;

  // predicted register set and window statistics
  wlm_pkg::cfg_t regs;
  logic [47:0]   win_start;
  logic [31:0]   n_pass;
  logic [47:0]   dur_sum;
  logic [31:0]   dur_max;
  logic [31:0]   gap_top;
  logic [31:0]   dur_at_gap_top;
  logic [31:0]   n_slow;
  logic [31:0]   n_stall;

  // reports predicted but not yet seen on the result channel
  wlm_pkg::out_item_t reports_due[$];
  wlm_pkg::out_item_t got;
  wlm_pkg::out_item_t want;

  function automatic logic [31:0] bump32(logic [31:0] v);
    return (&v) ? v : v + 32'd1;
  endfunction

  task automatic clear_window_stats();
    n_pass         = '0;
    dur_sum        = '0;
    dur_max        = '0;
    gap_top        = '0;
    dur_at_gap_top = '0;
    n_slow         = '0;
    n_stall        = '0;
  endtask

  task automatic report(input string what);
    if (errors < PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [47:0] g, input logic [47:0] w);
    if (g !== w) report($sformatf("%s got %0h want %0h", name, g, w));
  endtask

  // fold one pass into the window and queue a report when it closes an active window
  task automatic fold_pass(input wlm_pkg::in_item_t it);
    logic [48:0]        wide_sum;
    logic [47:0]        elapsed;
    wlm_pkg::out_item_t rpt;
    n_pass   = bump32(n_pass);
    wide_sum = {1'b0, dur_sum} + {17'd0, it.pass_time_us};
    dur_sum  = wide_sum[48] ? '1 : wide_sum[47:0];
    if (it.pass_time_us > dur_max) dur_max = it.pass_time_us;
    if (it.pass_time_us > regs.slow_threshold_us) n_slow = bump32(n_slow);
    if (it.gap_time_us > regs.stall_threshold_us) n_stall = bump32(n_stall);
    // a tie with the longest gap keeps the earlier pass
    if (it.gap_time_us > gap_top) begin
      gap_top        = it.gap_time_us;
      dur_at_gap_top = it.pass_time_us;
    end
    // a zero start means the window has not started yet
    if (win_start == '0) win_start = it.now_ms;
    elapsed = it.now_ms - win_start;
    if (elapsed >= {16'd0, regs.window_length_ms}) begin
      if (n_slow != '0 || n_stall != '0) begin
        rpt.pass_count         = n_pass;
        rpt.pass_time_sum      = dur_sum;
        rpt.pass_time_max      = dur_max;
        rpt.slow_count         = n_slow;
        rpt.gap_max            = gap_top;
        rpt.pass_after_gap_max = dur_at_gap_top;
        rpt.stall_count        = n_stall;
        reports_due.push_back(rpt);
      end
      win_start = it.now_ms;
      clear_window_stats();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      regs.slow_threshold_us  = wlm_pkg::SLOW_THRESHOLD_RST;
      regs.stall_threshold_us = wlm_pkg::STALL_THRESHOLD_RST;
      regs.window_length_ms   = wlm_pkg::WINDOW_LENGTH_RST;
      win_start               = '0;
      clear_window_stats();
      reports_due.delete();
    end else begin
      // result transfer against the oldest prediction
      if (out_valid && !out_stall) begin
        got = out_data;
        if (reports_due.size() == 0) begin
          report($sformatf("report with none expected, pass_count %0h", got.pass_count));
        end else begin
          want = reports_due.pop_front();
          check_field("pass_count", got.pass_count, want.pass_count);
          check_field("pass_time_sum", got.pass_time_sum, want.pass_time_sum);
          check_field("pass_time_max", got.pass_time_max, want.pass_time_max);
          check_field("slow_count", got.slow_count, want.slow_count);
          check_field("gap_max", got.gap_max, want.gap_max);
          check_field("pass_after_gap_max", got.pass_after_gap_max,
                      want.pass_after_gap_max);
          check_field("stall_count", got.stall_count, want.stall_count);
        end
      end
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          wlm_pkg::CFG_SLOW_THRESHOLD:  regs.slow_threshold_us  = cfg_wdata;
          wlm_pkg::CFG_STALL_THRESHOLD: regs.stall_threshold_us = cfg_wdata;
          wlm_pkg::CFG_WINDOW_LENGTH:   regs.window_length_ms   = cfg_wdata;
          default: ;
        endcase
      end
      // input transfer
      if (in_valid && !in_stall) fold_pass(in_data);
    end
    reports_due_n = reports_due.size();
  end

endmodule

// ===== verif/tb_windowed_latency_monitor.sv =====
`timescale 1ns / 100ps
// tb_windowed_latency_monitor: stimulus and verdict for the windowed latency monitor;
// depends on wlm_pkg, windowed_latency_monitor and wlm_report_checker
module tb_windowed_latency_monitor;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 6;
  localparam int HOLD_CYCLES    = 400;
  localparam int PRESSURE_ITEMS = 60;
  localparam int SEGMENTS       = 12;
  localparam int SEGMENT_ITEMS  = 150;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  wlm_pkg::in_item_t             in_data;
  logic                          out_valid;
  logic                          out_stall;
  wlm_pkg::out_item_t            out_data;
  logic                          cfg_we;
  logic [wlm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0]                   cfg_wdata;

  int            errors;
  int            reports_due_n;
  logic          in_took;
  int            in_idle_pct;
  int            out_idle_pct;
  int            sink_hold;
  int            quiet_cycles;
  logic [47:0]   clock_ms;
  wlm_pkg::cfg_t cur;

  windowed_latency_monitor uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  wlm_report_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .errors        (errors),
    .reports_due_n (reports_due_n)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // input transfer seen at the rising edge, read by the driver at the falling edge
  always @(posedge clk) begin
    in_took <= in_valid && !in_stall;
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL windowed_latency_monitor");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result receiver: random stalls, or a long hold-off when requested
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      out_stall <= 1'b1;
      sink_hold = sink_hold - 1;
    end else begin
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  function automatic wlm_pkg::in_item_t make_pass(logic [31:0] p, logic [31:0] g,
                                                  logic [47:0] t);
    wlm_pkg::in_item_t it;
    it.pass_time_us = p;
    it.gap_time_us  = g;
    it.now_ms       = t;
    return it;
  endfunction

  // values clustered on a threshold, with random and extreme ones mixed in
  function automatic logic [31:0] near_threshold(logic [31:0] thr);
    case ($urandom_range(5))
      0: return thr;
      1: return thr + 32'd1;
      2: return thr - 32'd1;
      3: return $urandom;
      4: return $urandom_range(255);
      default: return $urandom_range(1) ? '1 : '0;
    endcase
  endfunction

  // offer one item after random idle cycles and wait for its transfer
  task automatic push_pass(input wlm_pkg::in_item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(negedge clk);
    while (!in_took) @(negedge clk);
  endtask

  // stop offering, wait for every predicted report and for the pipeline to empty
  task automatic settle();
    in_valid <= 1'b0;
    while (reports_due_n != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // write all three registers one after another
  task automatic apply_settings(input wlm_pkg::cfg_t s);
    cur       = s;
    cfg_we    <= 1'b1;
    cfg_index <= wlm_pkg::CFG_SLOW_THRESHOLD;
    cfg_wdata <= s.slow_threshold_us;
    @(negedge clk);
    cfg_index <= wlm_pkg::CFG_STALL_THRESHOLD;
    cfg_wdata <= s.stall_threshold_us;
    @(negedge clk);
    cfg_index <= wlm_pkg::CFG_WINDOW_LENGTH;
    cfg_wdata <= s.window_length_ms;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly advancing timestamps, with random jumps and zero timestamps as noise
  task automatic random_pass(output wlm_pkg::in_item_t it);
    int          sel;
    int          step_max;
    logic [63:0] wide;
    sel      = $urandom_range(99);
    step_max = (cur.window_length_ms > 32'd30) ? 30 : int'(cur.window_length_ms) / 3 + 1;
    if (sel < 4) begin
      wide      = {$urandom, $urandom};
      it.now_ms = wide[47:0];
    end else if (sel < 6) begin
      it.now_ms = '0;
    end else begin
      clock_ms  = clock_ms + 48'($urandom_range(step_max));
      it.now_ms = clock_ms;
    end
    it.pass_time_us = near_threshold(cur.slow_threshold_us);
    it.gap_time_us  = near_threshold(cur.stall_threshold_us);
  endtask

  function automatic wlm_pkg::cfg_t segment_settings(int k);
    wlm_pkg::cfg_t s;
    case (k)
      0: begin
        s.slow_threshold_us  = '0;
        s.stall_threshold_us = '1;
        s.window_length_ms   = 32'd1;
      end
      1: begin
        s.slow_threshold_us  = '1;
        s.stall_threshold_us = '0;
        s.window_length_ms   = '0;
      end
      2: begin
        s.slow_threshold_us  = '1;
        s.stall_threshold_us = '1;
        s.window_length_ms   = 32'd3;
      end
      3: begin
        s.slow_threshold_us  = $urandom;
        s.stall_threshold_us = $urandom;
        s.window_length_ms   = $urandom;
      end
      4: begin
        s.slow_threshold_us  = $urandom_range(2000);
        s.stall_threshold_us = $urandom_range(100000);
        s.window_length_ms   = '1;
      end
      default: begin
        s.slow_threshold_us  = $urandom_range(2000);
        s.stall_threshold_us = $urandom_range(100000);
        s.window_length_ms   = $urandom_range(40, 1);
      end
    endcase
    return s;
  endfunction

  initial begin
    wlm_pkg::in_item_t it;
    wlm_pkg::cfg_t     s;
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_stall    = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    in_took      = 1'b0;
    in_idle_pct  = 37;
    out_idle_pct = 37;
    sink_hold    = 0;
    quiet_cycles = 0;
    clock_ms     = 48'd5000;
    cur.slow_threshold_us  = wlm_pkg::SLOW_THRESHOLD_RST;
    cur.stall_threshold_us = wlm_pkg::STALL_THRESHOLD_RST;
    cur.window_length_ms   = wlm_pkg::WINDOW_LENGTH_RST;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part at the reset register values
    push_pass(make_pass(32'd5, 32'd10, 48'd0));          // zero timestamp, not started
    push_pass(make_pass(32'd2000, 32'd10, 48'd100));
    push_pass(make_pass('1, '1, 48'd1100));              // extremes, closes
    push_pass(make_pass(32'd7, 32'd60000, 48'd1200));
    push_pass(make_pass(32'd9, 32'd60000, 48'd1300));    // tie on the longest gap
    push_pass(make_pass(32'd11, 32'd59999, 48'd1400));
    push_pass(make_pass(32'd0, 32'd0, 48'd2200));
    push_pass(make_pass(32'd1, 32'd1, 48'd2300));        // quiet window
    push_pass(make_pass(32'd1000, 32'd50000, 48'd3300));
    push_pass(make_pass(32'd5000, 32'd0, 48'd3400));
    push_pass(make_pass(32'd3, 32'd3, 48'd10));          // timestamp goes backwards
    push_pass(make_pass(32'd1001, 32'd50001, '1));
    push_pass(make_pass(32'd2000, 32'd0, 48'h3E7));      // wraps around the top
    push_pass(make_pass(32'd0, 32'd0, 48'h3E7 + 48'd999));
    push_pass(make_pass(32'd1, 32'd50001, 48'h3E7 + 48'd1000));
    push_pass(make_pass(32'd3, 32'd4, 48'd0));
    push_pass(make_pass(32'd2000, 32'd0, 48'd0));        // a zero start leaves the window unstarted
    push_pass(make_pass(32'd5, 32'd0, 48'd500));
    push_pass(make_pass(32'd6, 32'd0, 48'd1499));
    push_pass(make_pass(32'd7, 32'd0, 48'd1500));
    settle();

    // every item reports while the receiver holds off, so the block backs up
    s.slow_threshold_us  = '0;
    s.stall_threshold_us = '1;
    s.window_length_ms   = '0;
    apply_settings(s);
    sink_hold = HOLD_CYCLES;
    for (int i = 0; i < PRESSURE_ITEMS; i++) begin
      push_pass(make_pass($urandom | 32'd1, $urandom, 48'($urandom) | 48'd1));
    end
    settle();

    // random segments, each under its own register setting
    for (int k = 0; k < SEGMENTS; k++) begin
      apply_settings(segment_settings(k));
      in_idle_pct  = (k == 5) ? 0 : 37;
      out_idle_pct = (k == 5) ? 0 : 37;
      for (int i = 0; i < SEGMENT_ITEMS; i++) begin
        random_pass(it);
        push_pass(it);
      end
      settle();
    end

    if (errors == 0) begin
      $display("PASS windowed_latency_monitor");
    end else begin
      $display("FAIL windowed_latency_monitor");
    end
    $finish;
  end

endmodule
